// ===== src/adc_cell_polynomial_correction_defines.svh =====
// assertion helpers shared by the correction block
`ifndef ADC_CELL_POLYNOMIAL_CORRECTION_DEFINES_SVH
`define ADC_CELL_POLYNOMIAL_CORRECTION_DEFINES_SVH

`ifndef SYNTH

// property checked on every rising edge outside reset
`define ACPC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("acpc: assertion failed");

// property checked on every rising edge, reset included
`define ACPC_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("acpc: assertion failed");

`else

`define ACPC_ASSERT(label, clk, rst_n, prop)
`define ACPC_ASSERT_NR(label, clk, prop)

`endif

`endif

// ===== src/acpc_pkg.sv =====
package acpc_pkg;

  localparam int CHANNELS  = 32;
  localparam int CELLS     = 1024;
  localparam int TERMS     = 6;
  localparam int COEF_BITS = 40;

  // fixed field widths of the ports
  localparam int CH_W      = 5;
  localparam int CELL_W    = 10;
  localparam int POWER_W   = 3;
  localparam int COEF_IN_W = 40;
  localparam int SAMPLE_W  = 16;

  localparam int CH_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CELL_AW = $clog2(CELLS);
  localparam int ADDR_W  = CH_AW + CELL_AW;

  // term p is scaled by 2^-(FRAC_BASE + FRAC_STEP*p)
  localparam int FRAC_BASE = 16;
  localparam int FRAC_STEP = 10;
  // integer part kept from each term before clamping
  localparam int Q_W       = 20;
  // exact width of |c| * t^p for the highest power
  localparam int PROD_W    = COEF_BITS + CELL_W * (TERMS - 1);

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef logic [TERMS-1:0][COEF_BITS-1:0] coef_vec_t;

endpackage

// ===== src/acpc_ram.sv =====
module acpc_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/acpc_term_pipe.sv =====
`include "adc_cell_polynomial_correction_defines.svh"

module acpc_term_pipe (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                vld_i,
  input  logic [acpc_pkg::CH_W-1:0]           ch_i,
  input  logic [acpc_pkg::CELL_W-1:0]         idx_i,
  input  logic signed [acpc_pkg::SAMPLE_W-1:0] raw_i,
  input  acpc_pkg::coef_vec_t                 coef_i,
  output logic                                vld_o,
  output logic [acpc_pkg::CH_W-1:0]           ch_o,
  output logic [acpc_pkg::CELL_W-1:0]         idx_o,
  output logic signed [acpc_pkg::SAMPLE_W-1:0] value_o,
  output logic                                sat_o
);

  localparam int TERMS  = acpc_pkg::TERMS;
  localparam int PROD_W = acpc_pkg::PROD_W;
  localparam int Q_W    = acpc_pkg::Q_W;
  localparam int EXT_W  = PROD_W + Q_W;
  localparam int ACC_W  = Q_W + 3;
  localparam logic signed [ACC_W-1:0] V_MAX =
    ACC_W'((1 <<< (acpc_pkg::SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] V_MIN =
    ACC_W'(-(1 <<< (acpc_pkg::SAMPLE_W - 1)));

  typedef struct packed {
    logic signed [acpc_pkg::SAMPLE_W-1:0] v;
    logic                                 sat;
  } step_t;

  // one term: v - sign * |c| * t^p * 2^-s, truncated toward zero, then clamped
  function automatic step_t term_step(
    input logic [PROD_W-1:0]                  prod,
    input logic                               neg,
    input logic signed [acpc_pkg::SAMPLE_W-1:0] v,
    input logic                               sat,
    input int                                 p
  );
    logic [EXT_W-1:0]        pe;
    logic [EXT_W-1:0]        low_mask;
    logic [Q_W-1:0]          qf;
    logic                    big;
    logic                    fnz;
    logic signed [ACC_W-1:0] ip;
    logic signed [ACC_W-1:0] a;
    logic signed [ACC_W-1:0] r;
    int                      s;
    step_t                   res;
    s        = acpc_pkg::FRAC_BASE + acpc_pkg::FRAC_STEP * p;
    pe       = EXT_W'(prod);
    low_mask = ~({EXT_W{1'b1}} << s);
    fnz      = |(pe & low_mask);
    big      = |(pe >> (s + Q_W));
    qf       = Q_W'(pe >> s);
    ip       = big ? (ACC_W'(1) <<< Q_W) : ACC_W'({1'b0, qf});
    a        = neg ? (ACC_W'(v) + ip) : (ACC_W'(v) - ip);
    r        = a;
    // dropped fraction pulls the result back toward zero
    if (fnz && !neg && (a > 0)) begin
      r = a - ACC_W'(1);
    end
    if (fnz && neg && (a < 0)) begin
      r = a + ACC_W'(1);
    end
    res.sat = sat;
    if (r > V_MAX) begin
      r       = V_MAX;
      res.sat = 1'b1;
    end else if (r < V_MIN) begin
      r       = V_MIN;
      res.sat = 1'b1;
    end
    res.v = acpc_pkg::SAMPLE_W'(r);
    return res;
  endfunction

  logic                                 ch_ok;
  logic [TERMS-1:0]                     neg_d;
  acpc_pkg::coef_vec_t                  mag_d;

  logic [TERMS:0]                       vld_q;
  logic [acpc_pkg::CH_W-1:0]            ch_q  [TERMS+1];
  logic [acpc_pkg::CELL_W-1:0]          idx_q [TERMS+1];
  logic signed [acpc_pkg::SAMPLE_W-1:0] v_q   [TERMS+1];
  logic [TERMS:0]                       sat_q;
  logic [TERMS-1:0]                     neg_q [TERMS+1];
  logic [PROD_W-1:0]                    prod_q [TERMS+1][TERMS];

  logic [PROD_W-1:0]                    prod_d [TERMS][TERMS];
  step_t                                st_d   [TERMS];

  // prep stage: sign and magnitude of each coefficient, zero for an absent channel
  always_comb begin
    ch_ok = (32'(ch_i) < acpc_pkg::CHANNELS);
    for (int j = 0; j < TERMS; j++) begin
      neg_d[j] = ch_ok & coef_i[j][acpc_pkg::COEF_BITS-1];
      if (!ch_ok) begin
        mag_d[j] = '0;
      end else if (coef_i[j][acpc_pkg::COEF_BITS-1]) begin
        mag_d[j] = ~coef_i[j] + acpc_pkg::COEF_BITS'(1);
      end else begin
        mag_d[j] = coef_i[j];
      end
    end
  end

  // stage k retires term k and advances the higher powers by one factor of t
  for (genvar k = 0; k < TERMS; k++) begin : g_stage
    assign st_d[k] = term_step(prod_q[k][k], neg_q[k][k], v_q[k], sat_q[k], k);
    for (genvar j = 0; j < TERMS; j++) begin : g_lane
      if (j > k) begin : g_mul
        assign prod_d[k][j] = PROD_W'(prod_q[k][j] * idx_q[k]);
      end else begin : g_hold
        assign prod_d[k][j] = prod_q[k][j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[TERMS-1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q[0]   <= ch_i;
    idx_q[0]  <= idx_i;
    v_q[0]    <= raw_i;
    sat_q[0]  <= 1'b0;
    neg_q[0]  <= neg_d;
    for (int j = 0; j < TERMS; j++) begin
      prod_q[0][j] <= PROD_W'(mag_d[j]);
    end
    for (int k = 0; k < TERMS; k++) begin
      ch_q[k+1]  <= ch_q[k];
      idx_q[k+1] <= idx_q[k];
      v_q[k+1]   <= st_d[k].v;
      sat_q[k+1] <= st_d[k].sat;
      neg_q[k+1] <= neg_q[k];
      for (int j = 0; j < TERMS; j++) begin
        prod_q[k+1][j] <= prod_d[k][j];
      end
    end
  end

  assign vld_o   = vld_q[TERMS];
  assign ch_o    = ch_q[TERMS];
  assign idx_o   = idx_q[TERMS];
  assign value_o = v_q[TERMS];
  assign sat_o   = sat_q[TERMS];

  `ACPC_ASSERT(a_pipe_lat_fwd, clk_i, rst_ni, vld_i |-> ##(TERMS+1) vld_o)
  `ACPC_ASSERT(a_pipe_lat_bwd, clk_i, rst_ni, vld_o |-> $past(vld_i, TERMS+1))
  `ACPC_ASSERT(a_pipe_ch_kept, clk_i, rst_ni, vld_o |-> (ch_o == $past(ch_i, TERMS+1)))
  `ACPC_ASSERT(a_pipe_idx_kept, clk_i, rst_ni, vld_o |-> (idx_o == $past(idx_i, TERMS+1)))
  `ACPC_ASSERT_NR(a_pipe_rst_clear, clk_i, !rst_ni |-> (vld_q == '0))

endmodule

// ===== src/adc_cell_polynomial_correction.sv =====
// channel  dir  ports                                               transfer
// command  in   start, busy, op_i, channel_i, load_cell_i,          start && !busy
//               load_power_i, coefficient_i, sample_index_i,
//               start_cell_i, raw_sample_i
// result   out  valid_o, out_channel_o, out_index_o,                valid_o (one cycle)
//               corrected_sample_o, saturated_o
//
// one command per cycle; a sample's result leaves after its transfer through these registered stages in order:
// one coefficient store read, one sign/magnitude stage, one stage per polynomial term
// a load writes the coefficient store at its transfer and gives no result
// reset clears the pipeline valid bits only; the coefficient store is not cleared
// busy stays low and the pipeline never stalls, as results cannot be held off
`include "adc_cell_polynomial_correction_defines.svh"

module adc_cell_polynomial_correction (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   op_i,
  input  logic [acpc_pkg::CH_W-1:0]              channel_i,
  input  logic [acpc_pkg::CELL_W-1:0]            load_cell_i,
  input  logic [acpc_pkg::POWER_W-1:0]           load_power_i,
  input  logic signed [acpc_pkg::COEF_IN_W-1:0]  coefficient_i,
  input  logic [acpc_pkg::CELL_W-1:0]            sample_index_i,
  input  logic [acpc_pkg::CELL_W-1:0]            start_cell_i,
  input  logic signed [acpc_pkg::SAMPLE_W-1:0]   raw_sample_i,
  output logic                                   valid_o,
  output logic [acpc_pkg::CH_W-1:0]              out_channel_o,
  output logic [acpc_pkg::CELL_W-1:0]            out_index_o,
  output logic signed [acpc_pkg::SAMPLE_W-1:0]   corrected_sample_o,
  output logic                                   saturated_o
);

  localparam int  TERMS      = acpc_pkg::TERMS;
  localparam int  ADDR_W     = acpc_pkg::ADDR_W;
  localparam int  CELL_AW    = acpc_pkg::CELL_AW;
  localparam bit  CELLS_POW2 = (acpc_pkg::CELLS == (1 << CELL_AW));

  logic                                 accept;
  logic                                 load_ok;
  logic [acpc_pkg::CELL_W:0]            cell_sum;
  logic [CELL_AW-1:0]                   rd_cell;
  logic [ADDR_W-1:0]                    ram_addr;
  logic [TERMS-1:0]                     ram_we;
  logic [acpc_pkg::COEF_BITS-1:0]       ram_wdata;
  acpc_pkg::coef_vec_t                  ram_rdata;

  logic                                 a_vld_d;
  logic                                 a_vld_q;
  logic [acpc_pkg::CH_W-1:0]            a_ch_q;
  logic [acpc_pkg::CELL_W-1:0]          a_idx_q;
  logic signed [acpc_pkg::SAMPLE_W-1:0] a_raw_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    // readout cell wraps around the ring of storage cells
    cell_sum = {1'b0, sample_index_i} + {1'b0, start_cell_i};
    if (CELLS_POW2) begin
      rd_cell = CELL_AW'(cell_sum);
    end else if (32'(cell_sum) >= acpc_pkg::CELLS) begin
      rd_cell = CELL_AW'(32'(cell_sum) - 32'(acpc_pkg::CELLS));
    end else begin
      rd_cell = CELL_AW'(cell_sum);
    end

    load_ok = (32'(channel_i) < acpc_pkg::CHANNELS) &&
              (32'(load_cell_i) < acpc_pkg::CELLS) &&
              (32'(load_power_i) < TERMS);

    if (op_i == acpc_pkg::OP_LOAD) begin
      ram_addr = (ADDR_W'(channel_i) << CELL_AW) | ADDR_W'(load_cell_i);
    end else begin
      ram_addr = (ADDR_W'(channel_i) << CELL_AW) | ADDR_W'(rd_cell);
    end

    for (int p = 0; p < TERMS; p++) begin
      ram_we[p] = accept && (op_i == acpc_pkg::OP_LOAD) && load_ok &&
                  (32'(load_power_i) == p);
    end

    a_vld_d = accept && (op_i == acpc_pkg::OP_SAMPLE);
  end

  assign ram_wdata = acpc_pkg::COEF_BITS'(coefficient_i);

  // one store per power so that all terms of a cell are read together
  for (genvar p = 0; p < TERMS; p++) begin : g_store
    acpc_ram #(
      .DATA_W (acpc_pkg::COEF_BITS),
      .ADDR_W (ADDR_W)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[p]),
      .addr_i  (ram_addr),
      .wdata_i (ram_wdata),
      .rdata_o (ram_rdata[p])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= a_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_ch_q  <= channel_i;
    a_idx_q <= sample_index_i;
    a_raw_q <= raw_sample_i;
  end

  acpc_term_pipe u_pipe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (a_vld_q),
    .ch_i    (a_ch_q),
    .idx_i   (a_idx_q),
    .raw_i   (a_raw_q),
    .coef_i  (ram_rdata),
    .vld_o   (valid_o),
    .ch_o    (out_channel_o),
    .idx_o   (out_index_o),
    .value_o (corrected_sample_o),
    .sat_o   (saturated_o)
  );

  `ACPC_ASSERT(a_top_we_onehot, clk_i, rst_ni, $onehot0(ram_we))
  `ACPC_ASSERT(a_top_load_silent, clk_i, rst_ni, (ram_we != '0) |=> !a_vld_q)
  `ACPC_ASSERT(a_top_sample_out, clk_i, rst_ni, a_vld_d |-> ##(TERMS+2) valid_o)

endmodule
